/* hw/rtl/json_string_field_extractor_macros.svh */
// Assertion macros for the JSON string field extractor.
`ifndef JSON_STRING_FIELD_EXTRACTOR_MACROS_SVH
`define JSON_STRING_FIELD_EXTRACTOR_MACROS_SVH
`ifndef SYNTHESIS
`define JSFE_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define JSFE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define JSFE_ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`define JSFE_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/jsfe_pkg.sv */
package jsfe_pkg;

    localparam int MAX_KEY_DEF = 16;

    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;
    localparam logic [1:0] ST_OVERFLOW  = 2'd3;

    localparam logic [2:0] CFG_KEY_LOW  = 3'd0;
    localparam logic [2:0] CFG_KEY_HIGH = 3'd1;
    localparam logic [2:0] CFG_KEY_LEN  = 3'd2;
    localparam logic [2:0] CFG_CAPACITY = 3'd3;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_win_ctrl;

    typedef struct packed {
        logic       hit;
        logic       char_valid;
        logic [7:0] out_char;
        logic       finished;
        logic [1:0] status;
    } t_result;

endpackage

/* hw/rtl/json_string_field_extractor.sv */
// JSON string field extractor.
// The input channel (i_in_valid, o_in_ready) carries one document byte per
// word, with i_in_last on the final byte. The output channel (o_out_valid,
// i_out_ready) carries a word for each decoded value byte and one for the end
// of the extraction, which gives its status; a decoded byte and the end may
// share a word. Bytes that give nothing give no output word.
// The key, its length and the output capacity are written through the plain
// write port. The user must write them only while the block is idle; the
// block does not enforce this. The window compare and the escape decode sit
// between the input handshake and the output register, so a word appears in
// the cycle after its byte is accepted and a byte can be taken in every cycle
// unless a word waits: then the block takes the next byte only if the
// receiver takes the waiting word in the same cycle; otherwise input stalls.
// Reset clears the search state and the output register and loads the
// registers with an empty key and a capacity of one. After the final byte of a
// document the block rearms for the next one and keeps its registers.
`include "json_string_field_extractor_macros.svh"

module json_string_field_extractor #(
    parameter int MAX_KEY = jsfe_pkg::MAX_KEY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_char_valid,
    output logic [7:0]  o_out_char,
    output logic        o_finished,
    output logic [1:0]  o_status
);
    import jsfe_pkg::*;

    localparam int KW = $clog2(MAX_KEY + 1);

    logic [63:0]   r_key_low;
    logic [63:0]   r_key_high;
    logic [4:0]    r_key_len;
    logic [15:0]   r_capacity;
    logic [KW-1:0] klen;
    logic          accept;
    logic          match;
    t_win_ctrl     win_ctrl;
    t_result       res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
            r_key_len  <= '0;
            r_capacity <= 16'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                CFG_KEY_LEN:  r_key_len  <= i_cfg_data[4:0];
                CFG_CAPACITY: r_capacity <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign klen   = (r_key_len > 5'(MAX_KEY)) ? KW'(MAX_KEY) : KW'(r_key_len);
    assign accept = i_in_valid && o_in_ready;

    jsfe_window #(
        .MAX_KEY (MAX_KEY)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (win_ctrl),
        .i_byte  (i_in_byte),
        .i_key   ({r_key_high, r_key_low}),
        .i_klen  (klen),
        .o_match (match)
    );

    jsfe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_byte     (i_in_byte),
        .i_last     (i_in_last),
        .i_match    (match),
        .i_capacity (r_capacity),
        .o_win      (win_ctrl),
        .o_res      (res)
    );

    jsfe_outreg u_outreg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (accept),
        .i_res        (res),
        .i_ready      (i_out_ready),
        .o_valid      (o_out_valid),
        .o_free       (o_in_ready),
        .o_char_valid (o_char_valid),
        .o_out_char   (o_out_char),
        .o_finished   (o_finished),
        .o_status     (o_status)
    );

    // A word carries a byte, ends the extraction, or does both.
    `JSFE_ASSERT_IMPLY(a_word_has_content, i_clk, i_rst_n, o_out_valid,
        o_char_valid || o_finished)
    // An overflow never carries a byte with it.
    `JSFE_ASSERT_IMPLY(a_overflow_no_char, i_clk, i_rst_n,
        o_out_valid && o_finished && (o_status == ST_OVERFLOW), !o_char_valid)
    // A byte that is accepted with an open output slot and a result is shown next.
    `JSFE_ASSERT_NEXT(a_result_shown, i_clk, i_rst_n, accept && res.hit, o_out_valid)

endmodule

/* hw/rtl/jsfe_window.sv */
module jsfe_window #(
    parameter int MAX_KEY = jsfe_pkg::MAX_KEY_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  jsfe_pkg::t_win_ctrl           i_ctrl,
    input  logic [7:0]                    i_byte,
    input  logic [127:0]                  i_key,
    input  logic [$clog2(MAX_KEY+1)-1:0]  i_klen,
    output logic                          o_match
);
    import jsfe_pkg::*;

    localparam int DEPTH = MAX_KEY + 2;
    localparam int IW    = $clog2(DEPTH);
    localparam int SW    = $clog2(DEPTH + 1);

    logic [7:0]    r_win [DEPTH];
    logic [7:0]    n_win [DEPTH];
    logic [SW-1:0] r_seen;
    logic [SW-1:0] n_seen;
    logic [MAX_KEY-1:0] key_ok;
    logic [IW-1:0] tail_idx;

    always_comb begin
        n_win[0] = i_byte;
        for (int k = 1; k < DEPTH; k++) begin
            n_win[k] = r_win[k-1];
        end
        n_seen = (r_seen == SW'(DEPTH)) ? r_seen : r_seen + SW'(1);
    end

    // Key byte j sits klen - j places behind the closing quote.
    always_comb begin
        for (int j = 0; j < MAX_KEY; j++) begin
            key_ok[j] = (IW'(j) >= IW'(i_klen)) ||
                        (n_win[IW'(i_klen) - IW'(j)] == i_key[8*j +: 8]);
        end
        tail_idx = IW'(i_klen) + IW'(1);
        o_match = (n_seen >= SW'(i_klen) + SW'(2)) && (n_win[0] == CH_QUOTE) &&
                  (n_win[tail_idx] == CH_QUOTE) && (&key_ok);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (i_ctrl.clear) begin
            r_seen <= '0;
        end else if (i_ctrl.shift) begin
            r_seen <= n_seen;
        end
    end

endmodule

/* hw/rtl/jsfe_ctrl.sv */
module jsfe_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_byte,
    input  logic                i_last,
    input  logic                i_match,
    input  logic [15:0]         i_capacity,
    output jsfe_pkg::t_win_ctrl o_win,
    output jsfe_pkg::t_result   o_res
);
    import jsfe_pkg::*;

    typedef enum logic [2:0] {
        PH_SEARCH,
        PH_COLON,
        PH_SPACE,
        PH_BODY,
        PH_DONE
    } t_phase;

    t_phase      r_phase;
    t_phase      n_phase;
    logic        r_esc;
    logic        n_esc;
    logic [15:0] r_count;
    logic [15:0] n_count;
    logic        fin;
    logic [1:0]  st;
    logic        cv;
    logic [7:0]  ch;
    logic        emit;
    logic [7:0]  dec;
    logic        shift;

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

    function automatic logic [7:0] unescape(input logic [7:0] b);
        logic [7:0] r;
        case (b)
            CH_N:    r = CH_LF;
            CH_R:    r = CH_CR;
            CH_T:    r = CH_TAB;
            default: r = b;
        endcase
        return r;
    endfunction

    always_comb begin
        n_phase = r_phase;
        n_esc   = r_esc;
        n_count = r_count;
        fin     = 1'b0;
        st      = ST_OK;
        cv      = 1'b0;
        ch      = '0;
        emit    = 1'b0;
        dec     = i_byte;
        shift   = 1'b0;
        unique case (r_phase)
            PH_SEARCH: begin
                shift = 1'b1;
                if (i_match) begin
                    n_phase = PH_COLON;
                end
            end
            PH_COLON: begin
                if (i_byte == CH_COLON) begin
                    n_phase = PH_SPACE;
                end
            end
            PH_SPACE: begin
                if (i_byte == CH_QUOTE) begin
                    n_phase = PH_BODY;
                end else if (!is_space(i_byte)) begin
                    fin = 1'b1;
                    st  = ST_MALFORMED;
                end
            end
            PH_BODY: begin
                if (r_esc) begin
                    n_esc = 1'b0;
                    dec   = unescape(i_byte);
                    emit  = 1'b1;
                end else if (i_byte == CH_BACKSLASH) begin
                    n_esc = 1'b1;
                end else if (i_byte == CH_QUOTE) begin
                    fin = 1'b1;
                    st  = (r_count >= i_capacity) ? ST_OVERFLOW : ST_OK;
                end else begin
                    emit = 1'b1;
                end
                if (emit) begin
                    if ({1'b0, r_count} + 17'd1 >= {1'b0, i_capacity}) begin
                        fin = 1'b1;
                        st  = ST_OVERFLOW;
                    end else begin
                        cv      = 1'b1;
                        ch      = dec;
                        n_count = r_count + 16'd1;
                    end
                end
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase
        if (fin) begin
            n_phase = PH_DONE;
        end
        // The end of the document closes an extraction that is still open.
        if (i_last && !fin && (r_phase != PH_DONE)) begin
            fin = 1'b1;
            st  = (n_phase == PH_SEARCH) ? ST_NOT_FOUND : ST_MALFORMED;
        end
        if (i_last) begin
            n_phase = PH_SEARCH;
            n_esc   = 1'b0;
            n_count = '0;
        end
    end

    assign o_win.shift      = i_accept && shift;
    assign o_win.clear      = i_accept && i_last;
    assign o_res.hit        = cv || fin;
    assign o_res.char_valid = cv;
    assign o_res.out_char   = ch;
    assign o_res.finished   = fin;
    assign o_res.status     = st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEARCH;
            r_esc   <= 1'b0;
            r_count <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_esc   <= n_esc;
            r_count <= n_count;
        end
    end

endmodule

/* hw/rtl/jsfe_outreg.sv */
module jsfe_outreg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  jsfe_pkg::t_result i_res,
    input  logic              i_ready,
    output logic              o_valid,
    output logic              o_free,
    output logic              o_char_valid,
    output logic [7:0]        o_out_char,
    output logic              o_finished,
    output logic [1:0]        o_status
);
    import jsfe_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load && i_res.hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load && i_res.hit) begin
            r_res <= i_res;
        end
    end

    assign o_valid      = r_valid;
    assign o_char_valid = r_res.char_valid;
    assign o_out_char   = r_res.out_char;
    assign o_finished   = r_res.finished;
    assign o_status     = r_res.status;

endmodule
